// ----- rtl/core/assert_macros.svh -----
// Assertion macros used by the checker file of this block.
// Needs a clock named clk and a reset named rst in the scope of each use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge outside reset.
`define SSDI_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Checked on every rising edge, reset included.
`define SSDI_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ----- rtl/core/ssdi_psc_pkg.sv -----
// Types, constants and helper functions of the peak switch controller.
// No dependencies; used by ssdi_psc_cfg, ssdi_psc_fsm and the top level.
`default_nettype none

package ssdi_psc_pkg;

  localparam int SAMPLE_WIDTH = 16;
  localparam int COUNT_WIDTH  = 16;
  localparam int CFG_WIDTH    = 16;
  localparam int INDEX_WIDTH  = 4;
  // Wide enough for sample, threshold and their sum or difference.
  localparam int EXT_W = ((SAMPLE_WIDTH > CFG_WIDTH) ? SAMPLE_WIDTH : CFG_WIDTH) + 2;

  typedef logic signed [SAMPLE_WIDTH-1:0] sample_t;
  typedef logic signed [EXT_W-1:0]        ext_t;
  typedef logic [COUNT_WIDTH-1:0]         count_t;
  typedef logic [INDEX_WIDTH-1:0]         cfg_index_t;
  typedef logic [CFG_WIDTH-1:0]           cfg_data_t;

  typedef enum logic [INDEX_WIDTH-1:0] {
    REG_START_THRESHOLD = 4'd0,
    REG_RETREAT_MARGIN  = 4'd1,
    REG_SWITCH_TICKS    = 4'd2,
    REG_SETTLE_TICKS    = 4'd3
  } reg_index_t;

  localparam logic [14:0] START_THRESHOLD_RESET = 15'd30;
  localparam logic [14:0] RETREAT_MARGIN_RESET  = 15'd15;
  localparam logic [15:0] SWITCH_TICKS_RESET    = 16'd40;
  localparam logic [15:0] SETTLE_TICKS_RESET    = 16'd50;

  typedef struct packed {
    logic [14:0] start_threshold;
    logic [14:0] retreat_margin;
    logic [15:0] switch_ticks;
    logic [15:0] settle_ticks;
  } cfg_t;

  typedef enum logic [2:0] {
    PH_WAIT       = 3'd0,
    PH_POS_HALF   = 3'd1,
    PH_NEG_SWITCH = 3'd2,
    PH_NEG_SETTLE = 3'd3,
    PH_NEG_HALF   = 3'd4,
    PH_POS_SWITCH = 3'd5,
    PH_POS_SETTLE = 3'd6
  } phase_t;

  typedef enum logic [1:0] {
    DRV_OFF = 2'd0,
    DRV_POS = 2'd1,
    DRV_NEG = 2'd2
  } drive_t;

  function automatic ext_t ext_s(sample_t x);
    return EXT_W'(x);
  endfunction

  function automatic ext_t ext_u(logic [15:0] x);
    return $signed(EXT_W'(x));
  endfunction

  function automatic count_t load_count(logic [15:0] t);
    return COUNT_WIDTH'(t);
  endfunction

endpackage

`default_nettype wire

// ----- rtl/core/ssdi_psc_cfg.sv -----
// Configuration registers of the peak switch controller.
// Depends on ssdi_psc_pkg for the register map and reset values.
`default_nettype none

module ssdi_psc_cfg
  import ssdi_psc_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       cfg_write,
  input  wire cfg_index_t cfg_index,
  input  wire cfg_data_t  cfg_data,
  output cfg_t            cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.start_threshold <= START_THRESHOLD_RESET;
      cfg.retreat_margin  <= RETREAT_MARGIN_RESET;
      cfg.switch_ticks    <= SWITCH_TICKS_RESET;
      cfg.settle_ticks    <= SETTLE_TICKS_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_START_THRESHOLD: cfg.start_threshold <= cfg_data[14:0];
        REG_RETREAT_MARGIN:  cfg.retreat_margin  <= cfg_data[14:0];
        REG_SWITCH_TICKS:    cfg.switch_ticks    <= cfg_data;
        REG_SETTLE_TICKS:    cfg.settle_ticks    <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/ssdi_psc_fsm.sv -----
// Phase sequencer, peak trackers and tick counter of the controller.
// Depends on ssdi_psc_pkg; advances one step per enabled cycle.
`default_nettype none

module ssdi_psc_fsm
  import ssdi_psc_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    step,
  input  wire sample_t sample_q,
  input  wire cfg_t    cfg,
  output drive_t       drive_now
);

  phase_t  phase, phase_next;
  sample_t peak_high, peak_high_next;
  sample_t peak_low, peak_low_next;
  count_t  countdown, countdown_next;

  ext_t v, th, dz, hi_upd, lo_upd;
  sample_t hi_track, lo_track;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_WAIT;
      peak_high <= '0;
      peak_low  <= '0;
      countdown <= '0;
    end else if (step) begin
      phase     <= phase_next;
      peak_high <= peak_high_next;
      peak_low  <= peak_low_next;
      countdown <= countdown_next;
    end
  end

  always_comb begin
    v  = ext_s(sample_q);
    th = ext_u({1'b0, cfg.start_threshold});
    dz = ext_u({1'b0, cfg.retreat_margin});
    // Peaks are updated with this sample before the retreat test.
    hi_track = (v > ext_s(peak_high)) ? sample_q : peak_high;
    lo_track = (v < ext_s(peak_low))  ? sample_q : peak_low;
    hi_upd   = ext_s(hi_track) - dz;
    lo_upd   = ext_s(lo_track) + dz;

    phase_next     = phase;
    peak_high_next = peak_high;
    peak_low_next  = peak_low;
    countdown_next = countdown;
    drive_now      = DRV_OFF;

    case (phase)
      PH_WAIT: begin
        peak_high_next = sample_q;
        peak_low_next  = sample_q;
        if (v > th) begin
          phase_next = PH_POS_HALF;
        end else if (v < -th) begin
          phase_next = PH_NEG_HALF;
        end
      end
      PH_POS_HALF: begin
        peak_high_next = hi_track;
        if (v < hi_upd) begin
          phase_next     = PH_NEG_SWITCH;
          countdown_next = load_count(cfg.switch_ticks);
        end
      end
      PH_NEG_SWITCH, PH_POS_SWITCH: begin
        drive_now = (phase == PH_NEG_SWITCH) ? DRV_NEG : DRV_POS;
        if (countdown == '0) begin
          phase_next     = (phase == PH_NEG_SWITCH) ? PH_NEG_SETTLE : PH_POS_SETTLE;
          countdown_next = load_count(cfg.settle_ticks);
        end else begin
          countdown_next = countdown - 1'b1;
        end
      end
      PH_NEG_SETTLE: begin
        if (countdown == '0) begin
          phase_next    = PH_NEG_HALF;
          peak_low_next = sample_q;
        end else begin
          countdown_next = countdown - 1'b1;
        end
      end
      PH_NEG_HALF: begin
        peak_low_next = lo_track;
        if (v > lo_upd) begin
          phase_next     = PH_POS_SWITCH;
          countdown_next = load_count(cfg.switch_ticks);
        end
      end
      PH_POS_SETTLE: begin
        if (countdown == '0) begin
          phase_next     = PH_POS_HALF;
          peak_high_next = sample_q;
        end else begin
          countdown_next = countdown - 1'b1;
        end
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire

// ----- rtl/core/ssdi_peak_switch_controller_core.sv -----
// Top level of the synchronized-switch peak controller.
// Depends on ssdi_psc_pkg, ssdi_psc_cfg and ssdi_psc_fsm.
`default_nettype none

// One sample item enters per clock cycle while in_stall is low, and one drive
// item leaves for each sample, in order. The sample is held in an input
// register, the phase sequencer works on it there, and the drive code lands
// in the result register. A stalled result register holds its item;
// the input side then stalls only while the input register is also occupied,
// so throughput stays at one item per cycle whenever the output is not stalled.
// Configuration writes take effect on the next cycle and are meant for idle time.
module ssdi_peak_switch_controller_core
  import ssdi_psc_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire sample_t    sample,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [1:0]      drive,
  input  wire logic       cfg_write,
  input  wire cfg_index_t cfg_index,
  input  wire cfg_data_t  cfg_data
);

  cfg_t    cfg;
  drive_t  drive_now;
  logic    s1_valid;
  sample_t s1_sample;
  logic    out_free;
  logic    s1_adv;
  logic    in_take;

  assign out_free = !out_valid || !out_stall;
  assign s1_adv   = s1_valid && out_free;
  assign in_stall = s1_valid && !out_free;
  assign in_take  = in_valid && !in_stall;

  ssdi_psc_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  ssdi_psc_fsm u_fsm (
    .clk       (clk),
    .rst       (rst),
    .step      (s1_adv),
    .sample_q  (s1_sample),
    .cfg       (cfg),
    .drive_now (drive_now)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= in_take || (s1_valid && !s1_adv);
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_sample <= sample;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_adv) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      drive <= drive_now;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/ssdi_psc_checker.sv -----
// Port-level assertions for the peak switch controller, bound to the top level.
// Depends on assert_macros.svh.
`default_nettype none

`include "assert_macros.svh"

module ssdi_psc_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       in_valid,
  input wire logic       in_stall,
  input wire logic       out_valid,
  input wire logic       out_stall,
  input wire logic [1:0] drive
);

  // The input side only backs up when both pipeline slots are full.
  `SSDI_ASSERT(a_in_stall_cause, in_stall |-> (out_valid && out_stall), "input stalled without output stall")

  // An item taken while the output drains passes through the input register into the result register.
  `SSDI_ASSERT(a_latency, (in_valid && !in_stall) ##1 !out_stall |=> out_valid, "accepted item did not reach the output")

  // A stalled result item is held.
  `SSDI_ASSERT(a_out_hold, (out_valid && out_stall) |=> (out_valid && $stable(drive)), "stalled result changed")

  // Reset empties the result register.
  `SSDI_ASSERT_ALWAYS(a_reset_empty, rst |=> !out_valid, "result valid after reset")

endmodule

bind ssdi_peak_switch_controller_core ssdi_psc_checker u_ssdi_psc_checker (.*);

`default_nettype wire
